[src/csp_pkg.sv]
// Shared constants for the cylinder shell support point block.
// Holds default widths and configuration register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SHELL_RADIUS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLLISION_MARGIN = 2'd2;

endpackage

`default_nettype wire

[src/csp_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries a valid bit and a sideband vector alongside; uses csp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csp_sqrt #(
    parameter int W      = csp_pkg::DATA_WIDTH_DEF,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [SIDE_W-1:0]           in_side,
    input  wire logic [LANES-1:0][2*W-1:0]   rad,
    output logic                             out_valid,
    output logic [SIDE_W-1:0]                out_side,
    output logic [LANES-1:0][W-1:0]          root
);
    import csp_pkg::*;

    logic                         vld_reg  [0:W-1];
    logic [SIDE_W-1:0]            side_reg [0:W-1];
    logic [LANES-1:0][2*W-1:0]    rem_reg  [0:W-1];
    logic [LANES-1:0][W-1:0]      root_reg [0:W-1];

    for (genvar s = 0; s < W; s++) begin : g_stage
        localparam int I = W - 1 - s;

        logic                      vld_cur;
        logic [SIDE_W-1:0]         side_cur;
        logic [LANES-1:0][2*W-1:0] rem_cur;
        logic [LANES-1:0][W-1:0]   root_cur;
        logic [LANES-1:0][2*W-1:0] rem_next;
        logic [LANES-1:0][W-1:0]   root_next;

        if (s == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign side_cur = in_side;
            assign rem_cur  = rad;
            assign root_cur = '0;
        end
        else begin : g_rest
            assign vld_cur  = vld_reg[s-1];
            assign side_cur = side_reg[s-1];
            assign rem_cur  = rem_reg[s-1];
            assign root_cur = root_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [2*W:0] trial;

            always_comb
            begin
                trial = ({{(W+1){1'b0}}, root_cur[l]} << (I + 1))
                      + ({{(2*W){1'b0}}, 1'b1} << (2 * I));
                if ({1'b0, rem_cur[l]} >= trial) begin
                    rem_next[l]  = rem_cur[l] - trial[2*W-1:0];
                    root_next[l] = root_cur[l] | ({{(W-1){1'b0}}, 1'b1} << I);
                end
                else begin
                    rem_next[l]  = rem_cur[l];
                    root_next[l] = root_cur[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end
            else if (en) begin
                vld_reg[s] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                side_reg[s] <= side_cur;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_side  = side_reg[W-1];
    assign root      = root_reg[W-1];

endmodule

`default_nettype wire

[src/csp_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient is known to fit in W-1 bits; uses csp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csp_div #(
    parameter int W      = csp_pkg::DATA_WIDTH_DEF,
    parameter int LANES  = 5,
    parameter int SIDE_W = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [SIDE_W-1:0]           in_side,
    input  wire logic [LANES-1:0][2*W-2:0]   num,
    input  wire logic [LANES-1:0][W-1:0]     den,
    output logic                             out_valid,
    output logic [SIDE_W-1:0]                out_side,
    output logic [LANES-1:0][W-2:0]          quot
);
    import csp_pkg::*;

    localparam int Q  = W - 1;
    localparam int NW = 2 * W - 1;

    logic                       vld_reg  [0:Q-1];
    logic [SIDE_W-1:0]          side_reg [0:Q-1];
    logic [LANES-1:0][NW-1:0]   rem_reg  [0:Q-1];
    logic [LANES-1:0][W-1:0]    den_reg  [0:Q-1];
    logic [LANES-1:0][Q-1:0]    quot_reg [0:Q-1];

    for (genvar s = 0; s < Q; s++) begin : g_stage
        localparam int I = Q - 1 - s;

        logic                     vld_cur;
        logic [SIDE_W-1:0]        side_cur;
        logic [LANES-1:0][NW-1:0] rem_cur;
        logic [LANES-1:0][W-1:0]  den_cur;
        logic [LANES-1:0][Q-1:0]  quot_cur;
        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][Q-1:0]  quot_next;

        if (s == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign side_cur = in_side;
            assign rem_cur  = num;
            assign den_cur  = den;
            assign quot_cur = '0;
        end
        else begin : g_rest
            assign vld_cur  = vld_reg[s-1];
            assign side_cur = side_reg[s-1];
            assign rem_cur  = rem_reg[s-1];
            assign den_cur  = den_reg[s-1];
            assign quot_cur = quot_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NW-1:0] dsh;

            always_comb
            begin
                dsh = {{(NW-W){1'b0}}, den_cur[l]} << I;
                if (rem_cur[l] >= dsh) begin
                    rem_next[l]  = rem_cur[l] - dsh;
                    quot_next[l] = quot_cur[l] | ({{(Q-1){1'b0}}, 1'b1} << I);
                end
                else begin
                    rem_next[l]  = rem_cur[l];
                    quot_next[l] = quot_cur[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end
            else if (en) begin
                vld_reg[s] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                side_reg[s] <= side_cur;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_cur;
                quot_reg[s] <= quot_next;
            end
        end
    end

    assign out_valid = vld_reg[Q-1];
    assign out_side  = side_reg[Q-1];
    assign quot      = quot_reg[Q-1];

endmodule

`default_nettype wire

[src/cylinder_shell_support_point.sv]
// Top level of the cylinder shell support point block.
// Instantiates csp_sqrt and csp_div; uses csp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one direction request per cycle while s_axis_tready is high. Each request passes
// the input, square and sum registers, the square root pipeline (one root bit per stage),
// the numerator register, the divider pipeline (one quotient bit per stage) and the output
// register, in that order. When the output is held by m_axis_tready low, the whole
// pipeline stalls and s_axis_tready drops. Configuration writes are taken in any cycle
// and are meant to be made while no request is in flight.
module cylinder_shell_support_point #(
    parameter int DATA_WIDTH = csp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = csp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0 up: dir_x, dir_y, dir_z, zero padding.
    input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0 up: sup_x, sup_y, sup_z, zero padding.
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [DATA_WIDTH-1:0]             cfg_data
);
    import csp_pkg::*;

    localparam int W       = DATA_WIDTH;
    localparam int TDATA_W = ((3 * W + 7) / 8) * 8;
    localparam int SQ_SIDE = 3 * W + 5;
    localparam int DV_SIDE = 5;
    localparam logic [W-1:0] ONE_FX = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic en;

    logic [W-2:0] radius_reg;
    logic [W-2:0] height_reg;
    logic [W-2:0] margin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radius_reg <= ONE_FX[W-2:0];
            height_reg <= ONE_FX[W-2:0];
            margin_reg <= '0;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHELL_RADIUS:     radius_reg <= cfg_data[W-2:0];
                REG_HALF_HEIGHT:      height_reg <= cfg_data[W-2:0];
                REG_COLLISION_MARGIN: margin_reg <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    logic [3*W-1:0] out_data_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input stage: magnitudes, signs and the all-zero substitution.
    logic [W-1:0] dx, dy, dz, ax, ay, az;
    logic         allz;

    assign dx   = s_axis_tdata[W-1:0];
    assign dy   = s_axis_tdata[2*W-1:W];
    assign dz   = s_axis_tdata[3*W-1:2*W];
    assign ax   = dx[W-1] ? (~dx + 1'b1) : dx;
    assign ay   = dy[W-1] ? (~dy + 1'b1) : dy;
    assign az   = dz[W-1] ? (~dz + 1'b1) : dz;
    assign allz = (dx == '0) && (dy == '0) && (dz == '0);

    logic         a_valid_reg;
    logic [W-1:0] a_mx_reg, a_my_reg, a_mz_reg;
    logic         a_sx_reg, a_sy_reg, a_sz_reg, a_zneg_reg, a_xyz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end
        else if (en) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_mx_reg   <= allz ? ONE_FX : ax;
            a_my_reg   <= allz ? ONE_FX : ay;
            a_mz_reg   <= allz ? ONE_FX : az;
            a_sx_reg   <= allz | dx[W-1];
            a_sy_reg   <= allz | dy[W-1];
            a_sz_reg   <= allz | dz[W-1];
            a_zneg_reg <= dz[W-1];
            a_xyz_reg  <= (dx == '0) && (dy == '0);
        end
    end

    // Squares.
    logic           b_valid_reg;
    logic [2*W-1:0] b_qx_reg, b_qy_reg, b_qz_reg;
    logic [W-1:0]   b_mx_reg, b_my_reg, b_mz_reg;
    logic           b_sx_reg, b_sy_reg, b_sz_reg, b_zneg_reg, b_xyz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end
        else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            b_qx_reg   <= (2*W)'(a_mx_reg) * (2*W)'(a_mx_reg);
            b_qy_reg   <= (2*W)'(a_my_reg) * (2*W)'(a_my_reg);
            b_qz_reg   <= (2*W)'(a_mz_reg) * (2*W)'(a_mz_reg);
            b_mx_reg   <= a_mx_reg;
            b_my_reg   <= a_my_reg;
            b_mz_reg   <= a_mz_reg;
            b_sx_reg   <= a_sx_reg;
            b_sy_reg   <= a_sy_reg;
            b_sz_reg   <= a_sz_reg;
            b_zneg_reg <= a_zneg_reg;
            b_xyz_reg  <= a_xyz_reg;
        end
    end

    // Sums of squares.
    logic                 c_valid_reg;
    logic [1:0][2*W-1:0]  c_rad_reg;
    logic [SQ_SIDE-1:0]   c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_valid_reg <= 1'b0;
        end
        else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            c_rad_reg[0] <= b_qx_reg + b_qy_reg;
            c_rad_reg[1] <= b_qx_reg + b_qy_reg + b_qz_reg;
            c_side_reg   <= {b_mx_reg, b_my_reg, b_mz_reg, b_sx_reg, b_sy_reg,
                             b_sz_reg, b_zneg_reg, b_xyz_reg};
        end
    end

    logic                 sq_valid;
    logic [SQ_SIDE-1:0]   sq_side;
    logic [1:0][W-1:0]    sq_root;

    csp_sqrt #(
        .W      (W),
        .LANES  (2),
        .SIDE_W (SQ_SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_side   (c_side_reg),
        .rad       (c_rad_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    // Numerators for the five scaled components.
    logic [W-1:0] s_mx, s_my, s_mz;

    assign s_mx = sq_side[SQ_SIDE-1 -: W];
    assign s_my = sq_side[SQ_SIDE-W-1 -: W];
    assign s_mz = sq_side[SQ_SIDE-2*W-1 -: W];

    logic                   d_valid_reg;
    logic [4:0][2*W-2:0]    d_num_reg;
    logic [4:0][W-1:0]      d_den_reg;
    logic [DV_SIDE-1:0]     d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
        end
        else if (en) begin
            d_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_num_reg[0] <= (2*W-1)'(s_mx) * (2*W-1)'(radius_reg);
            d_num_reg[1] <= (2*W-1)'(s_my) * (2*W-1)'(radius_reg);
            d_num_reg[2] <= (2*W-1)'(s_mx) * (2*W-1)'(margin_reg);
            d_num_reg[3] <= (2*W-1)'(s_my) * (2*W-1)'(margin_reg);
            d_num_reg[4] <= (2*W-1)'(s_mz) * (2*W-1)'(margin_reg);
            d_den_reg[0] <= sq_root[0];
            d_den_reg[1] <= sq_root[0];
            d_den_reg[2] <= sq_root[1];
            d_den_reg[3] <= sq_root[1];
            d_den_reg[4] <= sq_root[1];
            d_side_reg   <= sq_side[DV_SIDE-1:0];
        end
    end

    logic                 dv_valid;
    logic [DV_SIDE-1:0]   dv_side;
    logic [4:0][W-2:0]    dv_quot;

    csp_div #(
        .W      (W),
        .LANES  (5),
        .SIDE_W (DV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_side   (d_side_reg),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quot      (dv_quot)
    );

    // Final sums and saturation.
    logic f_sx, f_sy, f_sz, f_zneg, f_xyz;

    assign {f_sx, f_sy, f_sz, f_zneg, f_xyz} = dv_side;

    function automatic logic signed [W:0] apply_sign(input logic [W-2:0] mag,
                                                     input logic neg);
        logic signed [W:0] v;
        v = $signed({2'b00, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic [W-1:0] saturate(input logic signed [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    logic signed [W:0] t_x, t_y, t_z, sum_x, sum_y, sum_z;

    always_comb
    begin
        t_x   = f_xyz ? $signed({2'b00, radius_reg}) : apply_sign(dv_quot[0], f_sx);
        t_y   = f_xyz ? '0 : apply_sign(dv_quot[1], f_sy);
        t_z   = apply_sign(height_reg, f_zneg);
        sum_x = t_x + apply_sign(dv_quot[2], f_sx);
        sum_y = t_y + apply_sign(dv_quot[3], f_sy);
        sum_z = t_z + apply_sign(dv_quot[4], f_sz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_data_reg <= {saturate(sum_z), saturate(sum_y), saturate(sum_x)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-3*W){1'b0}}, out_data_reg};

    // The input side stalls only while a finished result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

    // A request leaving the divider lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_valid) |=> m_axis_tvalid)
    else $error("result lost between divider and output register");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the cylinder shell support point block.
// Predicts each support point from the direction and register settings; uses csp_pkg.
`timescale 1ns / 1ps

module tb_top;

    import csp_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int TW = ((3*DW+7)/8)*8;
    localparam int LATENCY = 2*DW+4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [DW-1:0] z;
        logic [DW-1:0] y;
        logic [DW-1:0] x;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TW-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;

    cylinder_shell_support_point uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vec_t dir_pending[$];
    vec_t support_expected[$];
    logic [63:0] radius_q = 64'd1 << FB;
    logic [63:0] height_q = 64'd1 << FB;
    logic [63:0] margin_q = 64'd0;
    int errors = 0;
    int requests_sent = 0;
    int points_checked = 0;
    int watchdog = 0;
    bit idle_allowed = 1'b1;
    int src_gap = 0;
    int snk_gap = 0;
    int cfg_writes = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint scale_by(longint c, logic [63:0] s, logic [63:0] len);
        logic [63:0] mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = longint'((mag * s) / len);
        return (c < 0) ? -q : q;
    endfunction

    function automatic logic [DW-1:0] clamp(longint v);
        if (v > SAT_HI)
            v = SAT_HI;
        if (v < SAT_LO)
            v = SAT_LO;
        return v[DW-1:0];
    endfunction

    function automatic vec_t support_point(vec_t d);
        longint x;
        longint y;
        longint z;
        longint px;
        longint py;
        longint pz;
        logic [63:0] sxy;
        logic [63:0] len;
        vec_t r;
        x = longint'(signed'(d.x));
        y = longint'(signed'(d.y));
        z = longint'(signed'(d.z));
        if (x != 0 || y != 0)
        begin
            sxy = int_sqrt(x*x + y*y);
            px = scale_by(x, radius_q, sxy);
            py = scale_by(y, radius_q, sxy);
        end
        else
        begin
            px = longint'(radius_q);
            py = 0;
        end
        pz = (z < 0) ? -longint'(height_q) : longint'(height_q);
        if (margin_q != 0)
        begin
            if (x == 0 && y == 0 && z == 0)
            begin
                x = -(longint'(1) << FB);
                y = x;
                z = x;
            end
            len = int_sqrt(x*x + y*y + z*z);
            px += scale_by(x, margin_q, len);
            py += scale_by(y, margin_q, len);
            pz += scale_by(z, margin_q, len);
        end
        r.x = clamp(px);
        r.y = clamp(py);
        r.z = clamp(pz);
        return r;
    endfunction

    function automatic logic [DW-1:0] rand_component();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return DW'($urandom_range(0, 8)) - 4;
            4: return DW'(signed'($urandom_range(0, 2 << FB)) - (1 << FB));
            default: return $urandom();
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                support_expected.push_back(support_point(vec_t'(s_axis_tdata)));
                requests_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_allowed && $urandom_range(0, 15) == 0)
                begin
                    src_gap = $urandom_range(1, 13) - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (dir_pending.size() > 0)
                begin
                    s_axis_tdata <= dir_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        vec_t got;
        vec_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready)
                || (m_axis_tvalid && m_axis_tready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = vec_t'(m_axis_tdata[3*DW-1:0]);
                if (support_expected.size() == 0)
                begin
                    $error("unexpected support point %h", got);
                    errors++;
                end
                else
                begin
                    want = support_expected.pop_front();
                    points_checked++;
                    if (got.x !== want.x)
                    begin
                        $error("sup_x expected %h got %h", want.x, got.x);
                        errors++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("sup_y expected %h got %h", want.y, got.y);
                        errors++;
                    end
                    if (got.z !== want.z)
                    begin
                        $error("sup_z expected %h got %h", want.z, got.z);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_allowed && $urandom_range(0, 15) == 0)
            begin
                snk_gap = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d support points outstanding",
                    support_expected.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SHELL_RADIUS: radius_q = value & 32'h7fff_ffff;
            REG_HALF_HEIGHT: height_q = value & 32'h7fff_ffff;
            REG_COLLISION_MARGIN: margin_q = value & 32'h7fff_ffff;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic drain();
        wait (dir_pending.size() == 0 && !s_axis_tvalid);
        wait (support_expected.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic add_dir(logic [DW-1:0] x, logic [DW-1:0] y, logic [DW-1:0] z);
        vec_t d;
        d.x = x;
        d.y = y;
        d.z = z;
        dir_pending.push_back(d);
    endtask

    task automatic add_random(int count);
        repeat (count)
            add_dir(rand_component(), rand_component(), rand_component());
    endtask

    function automatic logic [DW-1:0] rand_reg();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 8 << FB);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_dir(0, 0, 0);
        add_dir(0, 0, 32'h8000_0000);
        add_dir(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_dir(32'h0001_0000, 0, 32'hffff_ffff);
        add_dir(0, 32'hffff_0000, 0);
        add_dir(1, 1, 1);
        add_dir(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        drain();

        write_reg(REG_COLLISION_MARGIN, 32'h0000_8000);
        write_reg(REG_UNUSED, 32'hdead_beef);
        add_dir(0, 0, 0);
        add_dir(0, 0, 5);
        add_dir(32'h8000_0000, 32'h7fff_ffff, 0);
        add_dir(3, 4, 32'hffff_fff4);
        drain();

        write_reg(REG_SHELL_RADIUS, 32'hffff_ffff);
        write_reg(REG_HALF_HEIGHT, 32'h7fff_ffff);
        write_reg(REG_COLLISION_MARGIN, 32'h7fff_ffff);
        add_dir(0, 0, 0);
        add_dir(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_dir(1, 0, 32'hffff_ffff);
        add_dir(0, 0, 1);
        drain();

        write_reg(REG_SHELL_RADIUS, 0);
        write_reg(REG_HALF_HEIGHT, 0);
        write_reg(REG_COLLISION_MARGIN, 0);
        add_dir(5, 32'hffff_fff0, 32'h8000_0000);
        add_dir(0, 0, 0);
        add_random(50);
        drain();

        repeat (5)
        begin
            write_reg(REG_SHELL_RADIUS, rand_reg());
            write_reg(REG_HALF_HEIGHT, rand_reg());
            write_reg(REG_COLLISION_MARGIN, rand_reg());
            add_random(60);
            drain();
        end

        idle_allowed = 1'b0;
        write_reg(REG_COLLISION_MARGIN, 32'h0002_0000);
        add_random(60);
        drain();

        $display("Checked %0d support points from %0d requests over %0d register writes.",
            points_checked, requests_sent, cfg_writes);
        $display("Covered edge directions, zero vectors, margin on and off, saturation.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/csp_pkg.sv
src/csp_sqrt.sv
src/csp_div.sv
src/cylinder_shell_support_point.sv
bench/tb_top.sv
